// ----- src/erg_pkg.sv -----
// ----------------------------------------------------------------------------
// erg_pkg
// Shared constants for the Euclidean rhythm generator.
// ----------------------------------------------------------------------------
`default_nettype none
package erg_pkg;
  localparam int STEPS_DEF   = 16;
  localparam int PULSE_W     = 5;
  localparam int PATTERN_W   = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
endpackage
`default_nettype wire

// ----- src/erg_round.sv -----
// ----------------------------------------------------------------------------
// erg_round
// One registered round of the Bjorklund grouping: pair leading groups with
// remainder groups one to one (the unpaired ones become the remainders), then hold once at most one remainder is left.
// ----------------------------------------------------------------------------
`default_nettype none
module erg_round
  import erg_pkg::*;
#(
  parameter int STEPS = STEPS_DEF,
  parameter int CW    = $clog2(STEPS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic             in_done,
  input  wire logic             in_sat,
  input  wire logic [STEPS-1:0] in_lb,
  input  wire logic [CW-1:0]    in_ll,
  input  wire logic [CW-1:0]    in_lc,
  input  wire logic [STEPS-1:0] in_rb,
  input  wire logic [CW-1:0]    in_rl,
  input  wire logic [CW-1:0]    in_rc,
  output logic                  valid,
  output logic                  done,
  output logic                  sat,
  output logic [STEPS-1:0]      lb,
  output logic [CW-1:0]         ll,
  output logic [CW-1:0]         lc,
  output logic [STEPS-1:0]      rb,
  output logic [CW-1:0]         rl,
  output logic [CW-1:0]         rc
);
  logic [2*STEPS-1:0] joined;
  logic               done_next;
  logic [STEPS-1:0]   lb_next, rb_next;
  logic [CW-1:0]      ll_next, lc_next, rl_next, rc_next;

  always_comb begin
    joined    = {{STEPS{1'b0}}, in_rb} << in_ll;
    done_next = in_done;
    lb_next   = in_lb;
    ll_next   = in_ll;
    lc_next   = in_lc;
    rb_next   = in_rb;
    rl_next   = in_rl;
    rc_next   = in_rc;
    if (!in_done) begin
      lb_next = in_lb | joined[STEPS-1:0];
      ll_next = CW'(in_ll + in_rl);
      if (in_lc <= in_rc) begin
        lc_next = in_lc;
        rc_next = CW'(in_rc - in_lc);
      end else begin
        lc_next = in_rc;
        rb_next = in_lb;
        rl_next = in_ll;
        rc_next = CW'(in_lc - in_rc);
      end
      done_next = (rc_next <= CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      done <= done_next;
      sat  <= in_sat;
      lb   <= lb_next;
      ll   <= ll_next;
      lc   <= lc_next;
      rb   <= rb_next;
      rl   <= rl_next;
      rc   <= rc_next;
    end
  end
endmodule
`default_nettype wire

// ----- src/erg_place.sv -----
// ----------------------------------------------------------------------------
// erg_place
// One registered placement step: lay one group into the rhythm word,
// leading groups first, then remainder groups.
// ----------------------------------------------------------------------------
`default_nettype none
module erg_place
  import erg_pkg::*;
#(
  parameter int STEPS = STEPS_DEF,
  parameter int CW    = $clog2(STEPS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [STEPS-1:0] in_word,
  input  wire logic [CW-1:0]    in_pos,
  input  wire logic [STEPS-1:0] in_lb,
  input  wire logic [CW-1:0]    in_ll,
  input  wire logic [CW-1:0]    in_lc,
  input  wire logic [STEPS-1:0] in_rb,
  input  wire logic [CW-1:0]    in_rl,
  input  wire logic [CW-1:0]    in_rc,
  output logic                  valid,
  output logic [STEPS-1:0]      word,
  output logic [CW-1:0]         pos,
  output logic [STEPS-1:0]      lb,
  output logic [CW-1:0]         ll,
  output logic [CW-1:0]         lc,
  output logic [STEPS-1:0]      rb,
  output logic [CW-1:0]         rl,
  output logic [CW-1:0]         rc
);
  logic [STEPS-1:0]   grp;
  logic [2*STEPS-1:0] shifted;
  logic [STEPS-1:0]   word_next;
  logic [CW-1:0]      pos_next, lc_next, rc_next;

  always_comb begin
    grp       = in_rb;
    pos_next  = in_pos;
    lc_next   = in_lc;
    rc_next   = in_rc;
    if (in_lc != '0) begin
      grp      = in_lb;
      pos_next = CW'(in_pos + in_ll);
      lc_next  = CW'(in_lc - CW'(1));
    end else if (in_rc != '0) begin
      pos_next = CW'(in_pos + in_rl);
      rc_next  = CW'(in_rc - CW'(1));
    end else begin
      grp = '0;
    end
    shifted   = {{STEPS{1'b0}}, grp} << in_pos;
    word_next = in_word | shifted[STEPS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word <= word_next;
      pos  <= pos_next;
      lb   <= in_lb;
      ll   <= in_ll;
      lc   <= lc_next;
      rb   <= in_rb;
      rl   <= in_rl;
      rc   <= rc_next;
    end
  end
endmodule
`default_nettype wire

// ----- src/euclidean_rhythm_generator.sv -----
// ----------------------------------------------------------------------------
// euclidean_rhythm_generator
// Spreads a pulse count evenly over STEPS steps and returns the rhythm word.
//
//   channel   dir  payload
//   s_axis    in   tdata[4:0] = pulse_count
//   m_axis    out  tdata[15:0] = pattern
//
// The pipeline is STEPS-1 grouping rounds, then STEPS group placements, one
// register stage each. A new transaction enters every cycle unless stalled.
// Reset empties the pipeline. An output stall freezes every stage at once.
// ----------------------------------------------------------------------------
`default_nettype none
module euclidean_rhythm_generator
  import erg_pkg::*;
#(
  parameter int STEPS = STEPS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [4:0] pulse_count
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // [15:0] pattern
);
  localparam int CW = $clog2(STEPS + 1);
  localparam int NR = STEPS - 1;

  logic en;
  logic [PULSE_W-1:0] pulse_count;

  logic             r_v [NR+1];
  logic             r_d [NR+1];
  logic             r_s [NR+1];
  logic [STEPS-1:0] r_lb[NR+1];
  logic [CW-1:0]    r_ll[NR+1];
  logic [CW-1:0]    r_lc[NR+1];
  logic [STEPS-1:0] r_rb[NR+1];
  logic [CW-1:0]    r_rl[NR+1];
  logic [CW-1:0]    r_rc[NR+1];

  logic             p_v [STEPS+1];
  logic [STEPS-1:0] p_w [STEPS+1];
  logic [CW-1:0]    p_p [STEPS+1];
  logic [STEPS-1:0] p_lb[STEPS+1];
  logic [CW-1:0]    p_ll[STEPS+1];
  logic [CW-1:0]    p_lc[STEPS+1];
  logic [STEPS-1:0] p_rb[STEPS+1];
  logic [CW-1:0]    p_rl[STEPS+1];
  logic [CW-1:0]    p_rc[STEPS+1];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign pulse_count   = s_axis_tdata[PULSE_W-1:0];

  always_comb begin
    r_v[0]  = s_axis_tvalid;
    r_lb[0] = STEPS'(1);
    r_ll[0] = CW'(1);
    r_rb[0] = '0;
    r_rl[0] = CW'(1);
    r_s[0]  = 1'b0;
    r_d[0]  = 1'b0;
    r_lc[0] = CW'(pulse_count);
    r_rc[0] = CW'(STEPS - int'(pulse_count));
    if (pulse_count == '0) begin
      r_d[0]  = 1'b1;
      r_lc[0] = '0;
      r_rc[0] = '0;
    end else if (int'(pulse_count) >= STEPS) begin
      r_d[0]  = 1'b1;
      r_s[0]  = 1'b1;
      r_lc[0] = '0;
      r_rc[0] = '0;
    end
  end

  for (genvar i = 0; i < NR; i++) begin : g_round
    erg_round #(.STEPS(STEPS), .CW(CW)) u_round (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(r_v[i]), .in_done(r_d[i]), .in_sat(r_s[i]),
      .in_lb(r_lb[i]), .in_ll(r_ll[i]), .in_lc(r_lc[i]),
      .in_rb(r_rb[i]), .in_rl(r_rl[i]), .in_rc(r_rc[i]),
      .valid(r_v[i+1]), .done(r_d[i+1]), .sat(r_s[i+1]),
      .lb(r_lb[i+1]), .ll(r_ll[i+1]), .lc(r_lc[i+1]),
      .rb(r_rb[i+1]), .rl(r_rl[i+1]), .rc(r_rc[i+1])
    );
  end

  assign p_v[0]  = r_v[NR];
  assign p_w[0]  = r_s[NR] ? {STEPS{1'b1}} : '0;
  assign p_p[0]  = '0;
  assign p_lb[0] = r_lb[NR];
  assign p_ll[0] = r_ll[NR];
  assign p_lc[0] = r_lc[NR];
  assign p_rb[0] = r_rb[NR];
  assign p_rl[0] = r_rl[NR];
  assign p_rc[0] = r_rc[NR];

  for (genvar k = 0; k < STEPS; k++) begin : g_place
    erg_place #(.STEPS(STEPS), .CW(CW)) u_place (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(p_v[k]), .in_word(p_w[k]), .in_pos(p_p[k]),
      .in_lb(p_lb[k]), .in_ll(p_ll[k]), .in_lc(p_lc[k]),
      .in_rb(p_rb[k]), .in_rl(p_rl[k]), .in_rc(p_rc[k]),
      .valid(p_v[k+1]), .word(p_w[k+1]), .pos(p_p[k+1]),
      .lb(p_lb[k+1]), .ll(p_ll[k+1]), .lc(p_lc[k+1]),
      .rb(p_rb[k+1]), .rl(p_rl[k+1]), .rc(p_rc[k+1])
    );
  end

  assign m_axis_tvalid = p_v[STEPS];
  assign m_axis_tdata  = OUT_TDATA_W'(p_w[STEPS]);
endmodule
`default_nettype wire

// ----- src/erg_checker.sv -----
// ----------------------------------------------------------------------------
// erg_checker
// Port-level checks for the Euclidean rhythm generator.
// ----------------------------------------------------------------------------
`default_nettype none
module erg_checker
  import erg_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output transaction changed");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !$isunknown(s_axis_tdata[PULSE_W-1:0]))
    else $error("input transaction carries unknown pulse count");
endmodule

bind euclidean_rhythm_generator erg_checker u_erg_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tdata(s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
